[hdl/rdc_pkg.sv]
// Package for the radix digit converter: field widths, fixed constants,
// controller/datapath command and status structs, and the alphabet lookup.
// No dependencies.
`default_nettype none

package rdc_pkg;

    // Field widths of the channels
    localparam int VALUE_W     = 64;
    localparam int RADIX_W     = 8;
    localparam int CHAR_W      = 8;
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 64;

    // Digit alphabet: eight 64-bit registers, eight characters each
    localparam int NUM_CHAR_REGS  = 8;
    localparam int CHARS_PER_REG  = 8;
    localparam int DIGIT_W        = 6;
    localparam int DIGIT_REM_W    = 7;

    // Legal radix range
    localparam int RADIX_MIN = 2;
    localparam int RADIX_MAX = 64;

    // Quotient bits retired per divider cycle
    localparam int DIV_BITS = 8;

    typedef logic [NUM_CHAR_REGS-1:0][CFG_DATA_W-1:0] chars_t;

    // Controller -> datapath
    typedef struct packed {
        logic load;       // capture a transaction with a legal radix
        logic div_en;     // advance the divider by one step
        logic rd_en;      // read the next digit from the buffer
        logic emit_load;  // load a digit character into the output register
        logic bad_load;   // load the bad-radix result
    } cmd_t;

    // Datapath -> controller
    typedef struct packed {
        logic radix_bad;  // incoming radix is outside the legal range
        logic conv_done;  // this divider cycle produces the final digit
        logic out_free;   // output register can take a new result
        logic ptr_zero;   // the digit being emitted is the least significant
    } status_t;

    // Alphabet character for a digit value
    function automatic logic [CHAR_W-1:0] char_lookup(input chars_t chars,
                                                       input logic [DIGIT_W-1:0] d);
        logic [CFG_DATA_W-1:0] word;
        begin
            word = chars[d[5:3]];
            return word[d[2:0]*CHAR_W +: CHAR_W];
        end
    endfunction

endpackage

`default_nettype wire

[hdl/rdc_if.sv]
// Valid/ready channel interfaces of the radix digit converter:
// input item, result item and configuration write.
// Depends on rdc_pkg.
`default_nettype none

interface rdc_in_if;
    logic                         valid;
    logic                         ready;
    logic [rdc_pkg::VALUE_W-1:0]  number_value;
    logic [rdc_pkg::RADIX_W-1:0]  radix;

    modport source (output valid, output number_value, output radix, input ready);
    modport sink   (input valid, input number_value, input radix, output ready);
endinterface

interface rdc_out_if;
    logic                         valid;
    logic                         ready;
    logic [rdc_pkg::CHAR_W-1:0]   digit_char;
    logic                         last_digit;
    logic                         bad_radix;

    modport source (output valid, output digit_char, output last_digit,
                    output bad_radix, input ready);
    modport sink   (input valid, input digit_char, input last_digit,
                    input bad_radix, output ready);
endinterface

interface rdc_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [rdc_pkg::CFG_INDEX_W-1:0] index;
    logic [rdc_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[hdl/rdc_ctrl.sv]
// Controller of the radix digit converter: sequences capture, division,
// buffer reads and result loads. Depends on rdc_pkg.
`default_nettype none

module rdc_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire rdc_pkg::status_t status,
    output rdc_pkg::cmd_t         cmd
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_DIV  = 5'b00010,
        ST_READ = 5'b00100,
        ST_EMIT = 5'b01000,
        ST_BAD  = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (status.radix_bad)
                    begin
                        state_next = ST_BAD;
                    end
                    else
                    begin
                        cmd.load   = 1'b1;
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV:
            begin
                cmd.div_en = 1'b1;
                if (status.conv_done)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                cmd.rd_en  = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit_load = 1'b1;
                    state_next    = status.ptr_zero ? ST_IDLE : ST_READ;
                end
            end
            ST_BAD:
            begin
                if (status.out_free)
                begin
                    cmd.bad_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

[hdl/rdc_datapath.sv]
// Datapath of the radix digit converter: 8-bit-per-cycle restoring divider,
// digit buffer memory, alphabet registers and output register.
// Depends on rdc_pkg.
`default_nettype none

module rdc_datapath #(
    parameter int MAX_DIGITS = 64,
    parameter int VALUE_BITS = 64
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire rdc_pkg::cmd_t                   cmd,
    output rdc_pkg::status_t                     status,
    input  wire logic [rdc_pkg::VALUE_W-1:0]     in_number_value,
    input  wire logic [rdc_pkg::RADIX_W-1:0]     in_radix,
    input  wire logic                            cfg_valid,
    input  wire logic [rdc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [rdc_pkg::CFG_DATA_W-1:0]  cfg_data,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic [rdc_pkg::CHAR_W-1:0]           out_digit_char,
    output logic                                 out_last_digit,
    output logic                                 out_bad_radix
);

    localparam int DIV_CYCLES = (VALUE_BITS + rdc_pkg::DIV_BITS - 1) / rdc_pkg::DIV_BITS;
    localparam int QW         = DIV_CYCLES * rdc_pkg::DIV_BITS;
    localparam int STEP_W     = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;
    localparam int ADDR_W     = $clog2(MAX_DIGITS);
    localparam int DW         = rdc_pkg::DIGIT_W;
    localparam int RW         = rdc_pkg::DIGIT_REM_W;

    // Divider state
    logic [QW-1:0]     quot_reg;
    logic [QW-1:0]     quot_next;
    logic [DW-1:0]     rem_reg;
    logic [DW-1:0]     rem_step;
    logic [RW-1:0]     radix_reg;
    logic [STEP_W-1:0] step_reg;
    logic [ADDR_W-1:0] wr_idx_reg;
    logic [ADDR_W-1:0] ptr_reg;
    logic [DW-1:0]     rd_data_reg;
    logic              step_last;
    logic              digit_done;

    // Digit buffer, least significant digit at address 0
    logic [DW-1:0] digit_mem [MAX_DIGITS];

    // Alphabet and output register
    rdc_pkg::chars_t               chars_reg;
    logic                          out_valid_reg;
    logic [rdc_pkg::CHAR_W-1:0]    out_char_reg;
    logic                          out_last_reg;
    logic                          out_bad_reg;

    // Radix check on the incoming transaction
    assign status.radix_bad = (in_radix < rdc_pkg::RADIX_W'(rdc_pkg::RADIX_MIN)) ||
                              (in_radix > rdc_pkg::RADIX_W'(rdc_pkg::RADIX_MAX));

    // Divider update for each div_en: DIV_BITS restoring steps on the top quotient byte
    always_comb
    begin
        logic [rdc_pkg::DIV_BITS-1:0] top;
        logic [rdc_pkg::DIV_BITS-1:0] qbits;
        logic [DW-1:0]                r;
        logic [RW-1:0]                t;
        top   = quot_reg[QW-1 -: rdc_pkg::DIV_BITS];
        qbits = '0;
        r     = rem_reg;
        for (int i = rdc_pkg::DIV_BITS - 1; i >= 0; i--)
        begin
            t = {r, top[i]};
            if (t >= radix_reg)
            begin
                t        = t - radix_reg;
                qbits[i] = 1'b1;
            end
            r = t[DW-1:0];
        end
        rem_step  = r;
        quot_next = (quot_reg << rdc_pkg::DIV_BITS) | QW'(qbits);
    end

    assign step_last  = (step_reg == STEP_W'(DIV_CYCLES - 1));
    assign digit_done = cmd.div_en && step_last;
    assign status.conv_done = digit_done &&
                              ((quot_next == '0) || (wr_idx_reg == ADDR_W'(MAX_DIGITS - 1)));
    assign status.ptr_zero  = (ptr_reg == '0);
    assign status.out_free  = !out_valid_reg || out_ready;

    // Divider and digit counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg   <= '0;
            wr_idx_reg <= '0;
            ptr_reg    <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                step_reg   <= '0;
                wr_idx_reg <= '0;
            end
            else if (cmd.div_en)
            begin
                if (step_last)
                begin
                    step_reg   <= '0;
                    wr_idx_reg <= wr_idx_reg + 1'b1;
                end
                else
                begin
                    step_reg <= step_reg + 1'b1;
                end
            end
            // Emission starts at the most significant digit just written
            if (status.conv_done)
            begin
                ptr_reg <= wr_idx_reg;
            end
            else if (cmd.emit_load)
            begin
                ptr_reg <= ptr_reg - 1'b1;
            end
        end
    end

    // Divider payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            quot_reg  <= QW'(in_number_value[VALUE_BITS-1:0]);
            rem_reg   <= '0;
            radix_reg <= in_radix[RW-1:0];
        end
        else if (cmd.div_en)
        begin
            quot_reg <= quot_next;
            rem_reg  <= step_last ? '0 : rem_step;
        end
    end

    // Digit buffer write and registered read
    always_ff @(posedge clk)
    begin
        if (digit_done)
        begin
            digit_mem[wr_idx_reg] <= rem_step;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= digit_mem[ptr_reg];
        end
    end

    // Alphabet registers; indexes past the list are ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chars_reg <= '0;
        end
        else if (cfg_valid && (cfg_index < rdc_pkg::CFG_INDEX_W'(rdc_pkg::NUM_CHAR_REGS)))
        begin
            chars_reg[cfg_index[2:0]] <= cfg_data;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit_load || cmd.bad_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_load)
        begin
            out_char_reg <= rdc_pkg::char_lookup(chars_reg, rd_data_reg);
            out_last_reg <= status.ptr_zero;
            out_bad_reg  <= 1'b0;
        end
        else if (cmd.bad_load)
        begin
            out_char_reg <= '0;
            out_last_reg <= 1'b1;
            out_bad_reg  <= 1'b1;
        end
    end

    assign out_valid      = out_valid_reg;
    assign out_digit_char = out_char_reg;
    assign out_last_digit = out_last_reg;
    assign out_bad_radix  = out_bad_reg;

endmodule

`default_nettype wire

[hdl/radix_digit_converter.sv]
// Radix digit converter: one transaction in, 1..MAX_DIGITS digit characters out.
// Sequence: capture, then the 8-bit-per-cycle divider forms the digits least significant
//   first; each digit is then read from the buffer, most significant first, and loaded.
// One transaction at a time; the next is taken once the final result is loaded.
// Bad radix: one result, loaded once the output register is free. Reset (rst_n, async)
// clears control and alphabet; the digit buffer has no reset and needs no clearing pass.
`default_nettype none

module radix_digit_converter #(
    parameter int MAX_DIGITS = 64,
    parameter int VALUE_BITS = 64
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    rdc_in_if.sink     in_chan,
    rdc_out_if.source  out_chan,
    rdc_cfg_if.sink    cfg_chan
);

    rdc_pkg::cmd_t    cmd;
    rdc_pkg::status_t status;

    // Configuration writes are always taken
    assign cfg_chan.ready = 1'b1;

    rdc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_chan.valid),
        .in_ready (in_chan.ready),
        .status   (status),
        .cmd      (cmd)
    );

    rdc_datapath #(
        .MAX_DIGITS (MAX_DIGITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .in_number_value (in_chan.number_value),
        .in_radix        (in_chan.radix),
        .cfg_valid       (cfg_chan.valid),
        .cfg_index       (cfg_chan.index),
        .cfg_data        (cfg_chan.data),
        .out_valid       (out_chan.valid),
        .out_ready       (out_chan.ready),
        .out_digit_char  (out_chan.digit_char),
        .out_last_digit  (out_chan.last_digit),
        .out_bad_radix   (out_chan.bad_radix)
    );

endmodule

`default_nettype wire

[hdl/rdc_checker.sv]
// Port-level checker for the radix digit converter, bound to the top level.
// Depends on rdc_pkg.
`default_nettype none

module rdc_checker (
    input wire logic                         clk,
    input wire logic                         rst_n,
    input wire logic                         in_valid,
    input wire logic                         in_ready,
    input wire logic                         out_valid,
    input wire logic                         out_ready,
    input wire logic [rdc_pkg::CHAR_W-1:0]   digit_char,
    input wire logic                         last_digit,
    input wire logic                         bad_radix
);

    // A bad-radix result is a lone, final result with a zero character
    a_bad_is_final: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && bad_radix) |-> (last_digit && (digit_char == '0)))
        else $error("bad-radix result not final or character nonzero");

    // The block is busy the cycle after it takes a transaction
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input taken on consecutive cycles");

    // No new transaction is taken while a run still has digits to deliver
    a_no_accept_mid_run: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && !last_digit) |-> !in_ready)
        else $error("input ready before the final digit was delivered");

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(digit_char) &&
                                       $stable(last_digit) && $stable(bad_radix)))
        else $error("stalled result changed");

endmodule

bind radix_digit_converter rdc_checker u_rdc_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_chan.valid),
    .in_ready   (in_chan.ready),
    .out_valid  (out_chan.valid),
    .out_ready  (out_chan.ready),
    .digit_char (out_chan.digit_char),
    .last_digit (out_chan.last_digit),
    .bad_radix  (out_chan.bad_radix)
);

`default_nettype wire
